// File: rtl/dpep_pkg.sv
// Shared types, constants and helper functions for the DER payload envelope parser.
// This package stands alone; every module of the parser imports it.
package dpep_pkg;

  // Longest long-form length field that is accepted, in count bytes.
  localparam int unsigned MAX_LENGTH_BYTES = 4;
  localparam int unsigned LBL_W = $clog2(MAX_LENGTH_BYTES + 1);

  // DER tags that the envelope uses.
  localparam logic [7:0] TAG_SEQ = 8'h30;
  localparam logic [7:0] TAG_IA5 = 8'h16;
  localparam logic [7:0] TAG_OCT = 8'h04;

  // Four-character codes of the known payload types and of the magic string.
  localparam logic [31:0] FCC_KRNL = "krnl";
  localparam logic [31:0] FCC_DTRE = "dtre";
  localparam logic [31:0] FCC_RDSK = "rdsk";
  localparam logic [31:0] FCC_TRST = "trst";
  localparam logic [31:0] FCC_RTSC = "rtsc";
  localparam logic [31:0] FCC_SEPF = "sepf";
  localparam logic [31:0] FCC_MAGIC = "IM4P";

  // Payload kind codes.
  localparam logic [2:0] KIND_SHORT = 3'd0;
  localparam logic [2:0] KIND_KRNL  = 3'd1;
  localparam logic [2:0] KIND_DTRE  = 3'd2;
  localparam logic [2:0] KIND_RDSK  = 3'd3;
  localparam logic [2:0] KIND_TRST  = 3'd4;
  localparam logic [2:0] KIND_SEPF  = 3'd5;
  localparam logic [2:0] KIND_OTHER = 3'd6;

  // Position of a string element inside the outer sequence.
  localparam logic [1:0] EL_MAGIC   = 2'd0;
  localparam logic [1:0] EL_TYPE    = 2'd1;
  localparam logic [1:0] EL_VERSION = 2'd2;
  localparam logic [1:0] EL_PAYLOAD = 2'd3;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_SEQ_LEN,
    PH_SEQ_LONG,
    PH_TAG,
    PH_ELEM_LEN,
    PH_ELEM_LONG,
    PH_CONTENT
  } dpep_phase_e;

  typedef struct packed {
    logic        start_image;
    logic [7:0]  data_byte;
    logic [31:0] total_length;
  } dpep_in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] content_offset;
    logic [31:0] content_size;
    logic [2:0]  payload_kind;
  } dpep_out_t;

  // Handshake between the pipeline stages: advance lets the held byte be parsed.
  typedef struct packed {
    logic valid;
    logic advance;
  } dpep_stage_ctl_t;

  // Expected character of the magic string at a given position.
  function automatic logic [7:0] magic_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = FCC_MAGIC[31:24];
      2'd1:    ch = FCC_MAGIC[23:16];
      2'd2:    ch = FCC_MAGIC[15:8];
      default: ch = FCC_MAGIC[7:0];
    endcase
    return ch;
  endfunction

  // Maps the first four bytes of the type string to a payload kind.
  function automatic logic [2:0] kind_of(input logic [31:0] chars, input logic len_ok);
    logic [2:0] k;
    if (!len_ok) begin
      k = KIND_SHORT;
    end else if (chars == FCC_KRNL) begin
      k = KIND_KRNL;
    end else if (chars == FCC_DTRE) begin
      k = KIND_DTRE;
    end else if (chars == FCC_RDSK) begin
      k = KIND_RDSK;
    end else if (chars == FCC_TRST || chars == FCC_RTSC) begin
      k = KIND_TRST;
    end else if (chars == FCC_SEPF) begin
      k = KIND_SEPF;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

endpackage

// File: rtl/der_payload_envelope_parser_unit.sv
// Top level of the DER payload envelope parser: input register, parser, result register.
// Depends on dpep_pkg, dpep_in_reg, dpep_parser and dpep_out_reg.
//
// This block walks an image one byte per transfer and checks its DER envelope: a
// SEQUENCE followed by three IA5 strings and an OCTET STRING, with short or long
// form lengths of up to four bytes that must be nonzero and fit the image. The
// first string must read IM4P, and the first four bytes of the second string
// select the payload kind. Each image, started by a transfer with start_image
// set (which also samples total_length), yields exactly one result: success with
// the offset, size and kind of the payload, or failure with all other fields
// zero. The result comes out for the byte that decides it; for a good image that
// is the last length byte of the OCTET STRING, whose contents are not read.
// Bytes after the result, or before the first image, produce nothing. The block
// accepts one byte every cycle. A byte is registered in the input register,
// is parsed by a single pass of combinational logic, and its result, if any,
// is offered from the result register on the next cycle. The input stalls
// only while the result register holds a result that the receiver is stalling.
// There is no configuration and no memory, so no clearing time follows reset.
module der_payload_envelope_parser_unit
  import dpep_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dpep_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dpep_out_t out_data_o
);

  dpep_stage_ctl_t ctl;
  dpep_in_t        item;
  logic            advance;
  logic            emit;
  dpep_out_t       result;

  dpep_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .ctl_o      (ctl),
    .item_o     (item)
  );

  // The parser works on the held byte in the same cycle the result register
  // is able to take whatever that byte produces.
  dpep_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .item_i   (item),
    .emit_o   (emit),
    .result_o (result)
  );

  dpep_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .result_i    (result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A failure result never carries payload information.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |->
      out_data_o.content_offset == '0 && out_data_o.content_size == '0 &&
      out_data_o.payload_kind == KIND_SHORT)
  else $error("failure result with nonzero payload fields");

  // A successful envelope always has a nonempty payload behind a full header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.status |->
      out_data_o.content_size != '0 && out_data_o.content_offset >= 32'd16 &&
      out_data_o.payload_kind <= KIND_OTHER)
  else $error("successful result with impossible payload fields");

  // The input side waits only behind a result that is itself being held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
  else $error("input stalled without a stalled result");

endmodule

// File: rtl/dpep_in_reg.sv
// Input register of the DER payload envelope parser: holds one byte transfer.
// Depends on dpep_pkg for the input payload type.
module dpep_in_reg
  import dpep_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dpep_in_t        in_data_i,
  input  logic            advance_i,
  output dpep_stage_ctl_t ctl_o,
  output dpep_in_t        item_o
);

  logic     valid_q, valid_d;
  dpep_in_t item_q;
  logic     take;

  // The held byte blocks a new transfer only while it cannot move on.
  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (advance_i || !valid_q) begin
      valid_d = take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_data_i;
    end
  end

  assign ctl_o.valid   = valid_q;
  assign ctl_o.advance = advance_i;
  assign item_o        = item_q;

endmodule

// File: rtl/dpep_parser.sv
// DER payload envelope parse state machine: one byte per cycle when not stalled.
// Depends on dpep_pkg for phases, tags, payload types and the kind mapping.
module dpep_parser
  import dpep_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dpep_stage_ctl_t ctl_i,
  input  dpep_in_t        item_i,
  output logic            emit_o,
  output dpep_out_t       result_o
);

  dpep_phase_e phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] rem_q, rem_d;     // bytes of the image after the current one
  logic [1:0]  elem_q, elem_d;
  logic [31:0] acc_q, acc_d;
  logic [LBL_W-1:0] lbl_q, lbl_d;
  logic [31:0] cbl_q, cbl_d;
  logic [2:0]  cnt_q, cnt_d;     // content bytes seen, saturating at four
  logic        magic_q, magic_d;
  logic [31:0] type_q, type_d;
  logic        type_ok_q, type_ok_d;

  logic        en;
  logic [7:0]  b;
  logic [6:0]  n;
  logic [31:0] acc_new;
  logic [31:0] len_val;
  logic [31:0] rem_cur;
  logic [31:0] pos_base;
  logic        len_done;
  logic        fail;
  logic        done_ok;
  logic        step;
  logic        magic_now;

  assign en = ctl_i.valid && ctl_i.advance;
  assign b  = item_i.data_byte;
  assign n  = b[6:0];
  assign acc_new = {acc_q[23:0], b};
  assign magic_now = magic_q && (b == magic_char(cnt_q[1:0]));

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    rem_d     = rem_q;
    elem_d    = elem_q;
    acc_d     = acc_q;
    lbl_d     = lbl_q;
    cbl_d     = cbl_q;
    cnt_d     = cnt_q;
    magic_d   = magic_q;
    type_d    = type_q;
    type_ok_d = type_ok_q;
    len_done  = 1'b0;
    len_val   = acc_q;
    fail      = 1'b0;
    done_ok   = 1'b0;
    step      = 1'b0;
    rem_cur   = rem_q;
    pos_base  = pos_q;
    emit_o    = 1'b0;
    result_o  = '0;

    if (en) begin
      if (item_i.start_image) begin
        pos_base  = '0;
        elem_d    = EL_MAGIC;
        acc_d     = '0;
        lbl_d     = '0;
        cbl_d     = '0;
        cnt_d     = '0;
        magic_d   = 1'b1;
        type_d    = '0;
        type_ok_d = 1'b0;
        if (item_i.total_length == '0 || b != TAG_SEQ) begin
          fail = 1'b1;
        end else begin
          phase_d = PH_SEQ_LEN;
          rem_cur = item_i.total_length - 32'd1;
          step    = 1'b1;
        end
      end else if (phase_q != PH_WAIT) begin
        step = 1'b1;
        case (phase_q)
          PH_SEQ_LEN, PH_ELEM_LEN: begin
            if (!b[7]) begin
              len_done = 1'b1;
              len_val  = {24'd0, b};
            end else if (n == '0 || n > 7'(MAX_LENGTH_BYTES)) begin
              fail = 1'b1;
            end else begin
              acc_d   = '0;
              lbl_d   = LBL_W'(n);
              phase_d = (phase_q == PH_SEQ_LEN) ? PH_SEQ_LONG : PH_ELEM_LONG;
            end
          end
          PH_SEQ_LONG, PH_ELEM_LONG: begin
            acc_d = acc_new;
            lbl_d = lbl_q - LBL_W'(1);
            if (lbl_q == LBL_W'(1)) begin
              len_done = 1'b1;
              len_val  = acc_new;
            end
          end
          PH_TAG: begin
            if (b != ((elem_q == EL_PAYLOAD) ? TAG_OCT : TAG_IA5)) begin
              fail = 1'b1;
            end else begin
              phase_d = PH_ELEM_LEN;
            end
          end
          PH_CONTENT: begin
            if (elem_q == EL_MAGIC) begin
              magic_d = magic_now;
            end else if (elem_q == EL_TYPE && cnt_q < 3'd4) begin
              type_d = {type_q[23:0], b};
            end
            if (cnt_q < 3'd4) begin
              cnt_d = cnt_q + 3'd1;
            end
            cbl_d = cbl_q - 32'd1;
            if (cbl_q == 32'd1) begin
              if (elem_q == EL_MAGIC && !magic_now) begin
                fail = 1'b1;
              end else begin
                elem_d  = elem_q + 2'd1;
                phase_d = PH_TAG;
              end
            end
          end
          default: begin
            fail = 1'b1;
          end
        endcase

        // A finished length must be nonzero and fit in what is left of the image.
        if (len_done) begin
          acc_d = len_val;
          if (len_val == '0 || len_val > rem_q) begin
            fail = 1'b1;
          end else if (phase_q == PH_SEQ_LEN || phase_q == PH_SEQ_LONG) begin
            elem_d  = EL_MAGIC;
            phase_d = PH_TAG;
          end else begin
            cbl_d   = len_val;
            cnt_d   = '0;
            phase_d = PH_CONTENT;
            case (elem_q)
              EL_MAGIC: begin
                if (len_val != 32'd4) begin
                  fail = 1'b1;
                end
                magic_d = 1'b1;
              end
              EL_TYPE: begin
                type_ok_d = (len_val >= 32'd4);
                type_d    = '0;
              end
              EL_VERSION: begin
              end
              default: begin
                done_ok = 1'b1;
              end
            endcase
          end
        end
      end

      // Running out of bytes while the parse still needs more is a failure.
      if (!fail && !done_ok && step) begin
        if (rem_cur == '0) begin
          fail = 1'b1;
        end else begin
          pos_d = pos_base + 32'd1;
          rem_d = rem_cur - 32'd1;
        end
      end

      if (fail) begin
        emit_o          = 1'b1;
        phase_d         = PH_WAIT;
        result_o.status = 1'b1;
      end else if (done_ok) begin
        emit_o                  = 1'b1;
        phase_d                 = PH_WAIT;
        result_o.status         = 1'b0;
        result_o.content_offset = pos_q + 32'd1;
        result_o.content_size   = len_val;
        result_o.payload_kind   = kind_of(type_q, type_ok_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      pos_q     <= '0;
      rem_q     <= '0;
      elem_q    <= EL_MAGIC;
      acc_q     <= '0;
      lbl_q     <= '0;
      cbl_q     <= '0;
      cnt_q     <= '0;
      magic_q   <= 1'b1;
      type_q    <= '0;
      type_ok_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      rem_q     <= rem_d;
      elem_q    <= elem_d;
      acc_q     <= acc_d;
      lbl_q     <= lbl_d;
      cbl_q     <= cbl_d;
      cnt_q     <= cnt_d;
      magic_q   <= magic_d;
      type_q    <= type_d;
      type_ok_q <= type_ok_d;
    end
  end

endmodule

// File: rtl/dpep_out_reg.sv
// Result register of the DER payload envelope parser: holds one result transfer.
// Depends on dpep_pkg for the result payload type.
module dpep_out_reg
  import dpep_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      emit_i,
  input  dpep_out_t result_i,
  output logic      advance_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dpep_out_t out_data_o
);

  logic      valid_q, valid_d;
  dpep_out_t data_q;

  // The register can take a new result when it is empty or being drained.
  assign advance_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = emit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && emit_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
